>>> design/assert_macros.svh
// assertion macros used by the id buffer majority pick rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/idbmp_pkg.sv
// types and constants of the id buffer majority pick block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package idbmp_pkg;

	localparam int KEY_W   = 24;
	localparam int COUNT_W = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

	typedef struct packed {
		logic [KEY_W-1:0]   picked_id;
		logic               found;
		logic [COUNT_W-1:0] winning_count;
	} result_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_UPDATE = 5'b00100,
		S_INSERT = 5'b01000,
		S_FINISH = 5'b10000
	} scan_state_t;

endpackage

`default_nettype wire

>>> design/idbmp_table.sv
// key and count table: single port synchronous ram with registered read data
// depends on idbmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module idbmp_table import idbmp_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int IDX_W       = 6
) (
	input  wire logic             clk,
	input  wire ram_ctl_t         ctl,
	input  wire logic [IDX_W-1:0] addr,
	input  wire entry_t           wdata,
	output entry_t                rdata
);

	entry_t mem_q [TABLE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/idbmp_scan.sv
// per pixel table search, count update and running best tracking
// depends on idbmp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module idbmp_scan import idbmp_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int IDX_W       = 6,
	parameter int UW          = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_ready,
	input  wire logic [KEY_W-1:0] pix_key,
	input  wire logic             pix_last,
	input  wire logic             out_busy,
	output logic                  res_load,
	output result_t               res,
	output ram_ctl_t              ram_ctl,
	output logic [IDX_W-1:0]      ram_addr,
	output entry_t                ram_wdata,
	input  wire entry_t           ram_rdata
);

	scan_state_t        state_q;
	logic [UW-1:0]      used_q;
	logic [UW-1:0]      rd_idx_q;
	logic [UW-1:0]      cmp_idx_q;
	logic               pend_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [COUNT_W-1:0] best_count_q;
	logic [KEY_W-1:0]   key_q;
	logic               last_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;

	logic               hit;
	logic               miss_end;
	logic               issue;
	logic               room;
	logic               do_write;
	logic               better;
	logic [COUNT_W-1:0] upd_cnt;

	always_comb begin
		hit      = pend_q && (ram_rdata.key == key_q);
		miss_end = pend_q && !hit && (cmp_idx_q == UW'(used_q - UW'(1)));
		issue    = (state_q == S_SCAN) && (rd_idx_q < used_q) && !hit;
		room     = (used_q != UW'(TABLE_DEPTH));
		do_write = (state_q == S_UPDATE) || ((state_q == S_INSERT) && room);
		if (state_q == S_INSERT) begin
			upd_cnt = COUNT_W'(1);
		end else if (hit_cnt_q == COUNT_MAX) begin
			upd_cnt = hit_cnt_q;
		end else begin
			upd_cnt = hit_cnt_q + COUNT_W'(1);
		end
		better = (upd_cnt > best_count_q) ||
			((upd_cnt == best_count_q) && (key_q < best_key_q));
		ram_ctl.rd_en = issue;
		ram_ctl.wr_en = do_write;
		if (issue) begin
			ram_addr = rd_idx_q[IDX_W-1:0];
		end else if (state_q == S_INSERT) begin
			ram_addr = used_q[IDX_W-1:0];
		end else begin
			ram_addr = hit_idx_q;
		end
		ram_wdata.key   = key_q;
		ram_wdata.count = upd_cnt;
		pix_ready = (state_q == S_IDLE);
		res_load  = (state_q == S_FINISH) && !out_busy;
		res.picked_id     = best_key_q;
		res.found         = (best_count_q != '0);
		res.winning_count = best_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			rd_idx_q     <= '0;
			cmp_idx_q    <= '0;
			pend_q       <= 1'b0;
			best_key_q   <= '0;
			best_count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					if (pix_valid) begin
						if (pix_key == '0) begin
							state_q <= pix_last ? S_FINISH : S_IDLE;
						end else if (used_q == '0) begin
							state_q <= S_INSERT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_UPDATE;
					end else if (miss_end) begin
						state_q <= S_INSERT;
					end
					pend_q <= issue;
					if (issue) begin
						cmp_idx_q <= rd_idx_q;
						rd_idx_q  <= rd_idx_q + UW'(1);
					end
				end
				S_UPDATE: begin
					if (better) begin
						best_key_q   <= key_q;
						best_count_q <= upd_cnt;
					end
					state_q <= last_q ? S_FINISH : S_IDLE;
				end
				S_INSERT: begin
					if (room) begin
						used_q <= used_q + UW'(1);
						if (better) begin
							best_key_q   <= key_q;
							best_count_q <= upd_cnt;
						end
					end
					state_q <= last_q ? S_FINISH : S_IDLE;
				end
				S_FINISH: begin
					if (!out_busy) begin
						used_q       <= '0;
						best_key_q   <= '0;
						best_count_q <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			key_q  <= pix_key;
			last_q <= pix_last;
		end
		if (hit && (state_q == S_SCAN)) begin
			hit_idx_q <= cmp_idx_q[IDX_W-1:0];
			hit_cnt_q <= ram_rdata.count;
		end
	end

	`ASSERT_CLK(a_used_bound, clk, arst_n, used_q <= UW'(TABLE_DEPTH),
		"table occupancy beyond depth")
	`ASSERT_IMPL(a_wr_state, clk, arst_n, ram_ctl.wr_en,
		state_q == S_UPDATE || state_q == S_INSERT, "table write outside update")
	`ASSERT_CLK(a_clear, clk, arst_n, res_load |=> (used_q == '0 && best_count_q == '0),
		"frame not cleared after result")
	`ASSERT_IMPL(a_best_zero, clk, arst_n, best_count_q == '0, best_key_q == '0,
		"best key set without count")

endmodule

`default_nettype wire

>>> design/id_buffer_majority_pick_core.sv
// id buffer majority pick: most frequent non-black id of a frame of pixels
// each id pixel is searched in the table ram one entry per cycle over the distinct ids so far,
// then its count is updated or a new entry is inserted; a black pixel skips the search
// pixel_stall holds further pixels until then; after the last pixel the result is registered
// async reset empties the table by its fill count; ram contents are not cleared
// depends on idbmp_pkg, idbmp_table, idbmp_scan
`timescale 1ns / 1ps
`default_nettype none

module id_buffer_majority_pick_core import idbmp_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	input  wire logic               pixel_valid,
	output logic                    pixel_stall,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	input  wire logic               last_pixel,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [KEY_W-1:0]        picked_id,
	output logic                    found,
	output logic [COUNT_W-1:0]      winning_count
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW    = $clog2(TABLE_DEPTH + 1);

	logic             swap_q;
	logic             result_valid_q;
	result_t          result_q;
	logic [KEY_W-1:0] key;
	logic             pix_ready;
	logic             out_busy;
	logic             res_load;
	result_t          res;
	ram_ctl_t         ram_ctl;
	logic [IDX_W-1:0] ram_addr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	assign cfg_ready   = 1'b1;
	assign key         = swap_q ? {red, green, blue} : {blue, green, red};
	assign pixel_stall = !pix_ready;
	assign out_busy    = result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				swap_q <= cfg_data;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res;
		end
	end

	assign result_valid  = result_valid_q;
	assign picked_id     = result_q.picked_id;
	assign found         = result_q.found;
	assign winning_count = result_q.winning_count;

	idbmp_scan #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W),
		.UW          (UW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pixel_valid),
		.pix_ready (pix_ready),
		.pix_key   (key),
		.pix_last  (last_pixel),
		.out_busy  (out_busy),
		.res_load  (res_load),
		.res       (res),
		.ram_ctl   (ram_ctl),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	idbmp_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W)
	) u_table (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> tb/sv/id_buffer_majority_pick_core_tb.sv
// testbench of id_buffer_majority_pick_core: pixel frames in, picked id out, checked per frame
// against an in-bench tally of the id table; depends on idbmp_pkg and the core rtl
`timescale 1ns / 1ps

module id_buffer_majority_pick_core_tb;
	import idbmp_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
	localparam int CHUNK_ITEMS = 100;
	localparam int NUM_CHUNKS = 6;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	typedef enum int {FR_SHORT, FR_NOMINAL, FR_FULL, FR_SATURATE} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data = 1'b0;
	logic                 pixel_valid = 1'b0;
	logic                 pixel_stall;
	logic [7:0]           red = 8'd0;
	logic [7:0]           green = 8'd0;
	logic [7:0]           blue = 8'd0;
	logic                 last_pixel = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [KEY_W-1:0]     picked_id;
	logic                 found;
	logic [COUNT_W-1:0]   winning_count;

	pixel_t               pending_pixels[$];
	result_t              expected_picks[$];
	logic                 pix_taken = 1'b0;
	logic                 cfg_taken = 1'b0;
	logic                 no_idle = 1'b0;
	int                   mismatches = 0;
	int                   stuck_cycles = 0;

	// id table as the block should hold it
	logic [KEY_W-1:0]     id_keys[TABLE_DEPTH];
	logic [COUNT_W-1:0]   id_counts[TABLE_DEPTH];
	int                   ids_used = 0;
	logic [KEY_W-1:0]     lead_key = '0;
	logic [COUNT_W-1:0]   lead_count = '0;
	logic                 swap_rb = 1'b0;

	id_buffer_majority_pick_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.picked_id(picked_id),
		.found(found),
		.winning_count(winning_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic tally_pixel(input pixel_t px);
		logic [7:0]         r;
		logic [7:0]         b;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] c;
		int                 slot;
		result_t            pick;
		r = swap_rb ? px.blue : px.red;
		b = swap_rb ? px.red : px.blue;
		key = {b, px.green, r};
		if (key != '0) begin
			slot = -1;
			for (int i = 0; i < ids_used; i++) begin
				if (slot < 0 && id_keys[i] == key)
					slot = i;
			end
			if (slot < 0 && ids_used < TABLE_DEPTH) begin
				slot = ids_used;
				id_keys[slot] = key;
				id_counts[slot] = '0;
				ids_used++;
			end
			if (slot >= 0) begin
				c = id_counts[slot];
				if (c != COUNT_MAX)
					c = c + 1'b1;
				id_counts[slot] = c;
				if (c > lead_count || (c == lead_count && key < lead_key)) begin
					lead_count = c;
					lead_key = key;
				end
			end
		end
		if (px.last) begin
			if (lead_count != '0) begin
				pick.picked_id = lead_key;
				pick.found = 1'b1;
				pick.winning_count = lead_count;
			end else begin
				pick = '0;
			end
			expected_picks.push_back(pick);
			ids_used = 0;
			lead_key = '0;
			lead_count = '0;
		end
	endtask

	// pixel driver and result stall
	always @(negedge clk) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (!pixel_valid || pix_taken) begin
			if (pending_pixels.size() != 0 && (no_idle || $urandom_range(99) >= 12)) begin
				{red, green, blue, last_pixel} <= pending_pixels.pop_front();
				pixel_valid <= 1'b1;
			end else begin
				pixel_valid <= 1'b0;
			end
		end
		result_stall <= !no_idle && ($urandom_range(99) < 12);
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin : watch_ports
		result_t want;
		logic    pix_acc;
		logic    res_acc;
		logic    cfg_acc;
		pix_acc = pixel_valid && !pixel_stall;
		res_acc = result_valid && !result_stall;
		cfg_acc = cfg_valid && cfg_ready;
		pix_taken <= pix_acc;
		cfg_taken <= cfg_acc;
		if (arst_n) begin
			if (pix_acc)
				tally_pixel({red, green, blue, last_pixel});
			if (res_acc) begin
				if (expected_picks.size() == 0) begin
					report_mismatch("unexpected item, picked_id", 32'(picked_id), 32'd0);
				end else begin
					want = expected_picks.pop_front();
					if (picked_id !== want.picked_id)
						report_mismatch("picked_id", 32'(picked_id), 32'(want.picked_id));
					if (found !== want.found)
						report_mismatch("found", 32'(found), 32'(want.found));
					if (winning_count !== want.winning_count)
						report_mismatch("winning_count", 32'(winning_count),
							32'(want.winning_count));
				end
			end
			if (pix_acc || res_acc || cfg_acc)
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("id_buffer_majority_pick_core verification failed");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		int p;
		p = $urandom_range(99);
		if (p < 20)
			return 8'h00;
		if (p < 30)
			return 8'hff;
		return 8'($urandom_range(255));
	endfunction

	task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic last);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.last = last;
		pending_pixels.push_back(px);
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || pixel_valid || expected_picks.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_swap(input logic v);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_taken)
			@(negedge clk);
		swap_rb = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_frame(input frame_kind_t kind, inout int items);
		logic [23:0] pool[6];
		int          n;
		int          len;
		int          p;
		int          j;
		logic [23:0] hot;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			pool[i] = {pick_byte(), pick_byte(), pick_byte()};
		case (kind)
			FR_SHORT, FR_NOMINAL: begin
				len = (kind == FR_NOMINAL) ? 64 : $urandom_range(1, 16);
				for (int i = 0; i < len; i++) begin
					p = $urandom_range(99);
					if (p < 12)
						add_pixel(8'h00, 8'h00, 8'h00, i == len - 1);
					else if (p < 17)
						add_pixel(pick_byte(), pick_byte(), pick_byte(), i == len - 1);
					else begin
						j = $urandom_range(n - 1);
						add_pixel(pool[j][7:0], pool[j][15:8], pool[j][23:16], i == len - 1);
					end
				end
				items += len;
			end
			FR_FULL: begin
				// distinct red bytes fill the table, later ones are dropped
				for (int i = 0; i < 70; i++)
					add_pixel(8'(i + 1), pick_byte(), 8'($urandom_range(255)), 1'b0);
				for (int i = 0; i < 12; i++) begin
					j = (i < 4) ? 69 : $urandom_range(69);
					add_pixel(8'(j + 1), 8'h00, 8'h00, 1'b0);
				end
				add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
				items += 83;
			end
			FR_SATURATE: begin
				hot = {pick_byte(), pick_byte(), 8'($urandom_range(1, 255))};
				for (int i = 0; i < 140; i++) begin
					if ($urandom_range(99) < 5)
						add_pixel(pick_byte(), pick_byte(), pick_byte(), i == 139);
					else
						add_pixel(hot[7:0], hot[15:8], hot[23:16], i == 139);
				end
				items += 140;
			end
			default: ;
		endcase
	endtask

	initial begin
		int items;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_swap(1'b0);

		// directed, red and blue in place
		add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		add_pixel(8'hff, 8'hff, 8'hff, 1'b1);
		add_pixel(8'h05, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h03, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h05, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h03, 8'h00, 8'h00, 1'b1);
		add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h01, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h01, 1'b0);
		add_pixel(8'h80, 8'h80, 8'h80, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		add_pixel(8'h01, 8'h02, 8'h03, 1'b0);
		add_pixel(8'h01, 8'h02, 8'h03, 1'b1);

		// directed, red and blue swapped
		write_swap(1'b1);
		add_pixel(8'h12, 8'h34, 8'h56, 1'b0);
		add_pixel(8'h56, 8'h34, 8'h12, 1'b0);
		add_pixel(8'h56, 8'h34, 8'h12, 1'b1);
		add_pixel(8'hff, 8'h00, 8'h00, 1'b1);
		add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		write_swap(1'b0);

		// random frames in chunks, one chunk without idling
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			no_idle = (c == 2);
			items = 0;
			if (c == 1)
				add_frame(FR_FULL, items);
			if (c == 4)
				add_frame(FR_SATURATE, items);
			while (items < CHUNK_ITEMS) begin
				if ($urandom_range(99) < 8)
					add_frame(FR_NOMINAL, items);
				else
					add_frame(FR_SHORT, items);
			end
			if (c % 2 == 1)
				write_swap(1'($urandom_range(1)));
			else
				drain();
		end
		no_idle = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_picks.size() == 0) begin
			$display("id_buffer_majority_pick_core verification clean");
		end else begin
			$display("id_buffer_majority_pick_core verification failed");
		end
		$finish;
	end

endmodule
